// ----- src/apbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Affine point/box transform package
// Shared constants and types for the fixed-point affine transform block.
// ----------------------------------------------------------------------------
package apbt_pkg;

    // Fraction bits of every Q format value in the block.
    localparam int FRAC_BITS = 16;

    // Width of one rounded product and of one row sum with its three terms
    // and the translation added.
    localparam int PROD_W = 64 - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;

    localparam int NUM_REGS = 6;

    // Saturation bounds of the signed 32-bit result range.
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

    typedef logic [1:0]  t_cmd;
    typedef logic [2:0]  t_reg_idx;
    typedef logic [63:0] t_cfg_word;

    // Command codes. Code 3 is decoded by its high bit and acts as box mode.
    localparam t_cmd CMD_VECTOR = 2'd0;
    localparam t_cmd CMD_POINT  = 2'd1;
    localparam t_cmd CMD_BOX    = 2'd2;

    // Register indexes (byte address is eight times the index).
    localparam t_reg_idx REG_ROW0_XY  = 3'd0;
    localparam t_reg_idx REG_ROW0_ZO  = 3'd1;
    localparam t_reg_idx REG_ROW1_XY  = 3'd2;
    localparam t_reg_idx REG_ROW1_ZO  = 3'd3;
    localparam t_reg_idx REG_ROW2_XY  = 3'd4;
    localparam t_reg_idx REG_ROW2_ZO  = 3'd5;

    // Reset values give the identity transform.
    localparam t_cfg_word RST_ROW0_XY = 64'h0000_0000_0001_0000;
    localparam t_cfg_word RST_ROW0_ZO = 64'h0000_0000_0000_0000;
    localparam t_cfg_word RST_ROW1_XY = 64'h0001_0000_0000_0000;
    localparam t_cfg_word RST_ROW1_ZO = 64'h0000_0000_0000_0000;
    localparam t_cfg_word RST_ROW2_XY = 64'h0000_0000_0000_0000;
    localparam t_cfg_word RST_ROW2_ZO = 64'h0000_0000_0001_0000;

endpackage

// ----- src/affine_point_box_transform_top.sv -----
// ----------------------------------------------------------------------------
// Affine point/box transform, top level
// Applies a configured 3x4 fixed-point affine matrix to a vector, a point or
// an axis-aligned box in a five-stage pipeline.
// ----------------------------------------------------------------------------
// A request that is accepted passes through the registers of stages A to E
// in order, and the last of them drives its result strobe on o_done.
// Throughput: one request per cycle; busy is never raised, since every stage
// advances each cycle and the receiver takes each result as it appears.
// The rate is set by the bank of eighteen registered 32x32 multipliers.
// Reset (synchronous, active low) clears all valid bits and loads the
// identity matrix into the configuration registers.
// ----------------------------------------------------------------------------
module affine_point_box_transform_top (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Request channel
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_command,
    input  logic signed [31:0]  i_first_x,
    input  logic signed [31:0]  i_first_y,
    input  logic signed [31:0]  i_first_z,
    input  logic signed [31:0]  i_second_x,
    input  logic signed [31:0]  i_second_y,
    input  logic signed [31:0]  i_second_z,

    // Result channel
    output logic                o_done,
    output logic signed [31:0]  o_low_x,
    output logic signed [31:0]  o_low_y,
    output logic signed [31:0]  o_low_z,
    output logic signed [31:0]  o_high_x,
    output logic signed [31:0]  o_high_y,
    output logic signed [31:0]  o_high_z,
    output logic                o_overflow,

    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Each 64-bit word holds two signed Q16.16
    // entries: the low half in bits 31:0 and the high half in bits 63:32.
    // Writes must only happen while the pipeline is empty (the block does not
    // enforce this), so the stages read these registers directly.
    // ------------------------------------------------------------------
    apbt_pkg::t_cfg_word r_cfg [apbt_pkg::NUM_REGS];
    apbt_pkg::t_reg_idx  w_idx;
    logic                w_cfg_wr;

    assign pready   = 1'b1;
    assign w_idx    = paddr[5:3];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[apbt_pkg::REG_ROW0_XY] <= apbt_pkg::RST_ROW0_XY;
            r_cfg[apbt_pkg::REG_ROW0_ZO] <= apbt_pkg::RST_ROW0_ZO;
            r_cfg[apbt_pkg::REG_ROW1_XY] <= apbt_pkg::RST_ROW1_XY;
            r_cfg[apbt_pkg::REG_ROW1_ZO] <= apbt_pkg::RST_ROW1_ZO;
            r_cfg[apbt_pkg::REG_ROW2_XY] <= apbt_pkg::RST_ROW2_XY;
            r_cfg[apbt_pkg::REG_ROW2_ZO] <= apbt_pkg::RST_ROW2_ZO;
        end else if (w_cfg_wr) begin
            case (w_idx)
                apbt_pkg::REG_ROW0_XY: r_cfg[apbt_pkg::REG_ROW0_XY] <= pwdata;
                apbt_pkg::REG_ROW0_ZO: r_cfg[apbt_pkg::REG_ROW0_ZO] <= pwdata;
                apbt_pkg::REG_ROW1_XY: r_cfg[apbt_pkg::REG_ROW1_XY] <= pwdata;
                apbt_pkg::REG_ROW1_ZO: r_cfg[apbt_pkg::REG_ROW1_ZO] <= pwdata;
                apbt_pkg::REG_ROW2_XY: r_cfg[apbt_pkg::REG_ROW2_XY] <= pwdata;
                apbt_pkg::REG_ROW2_ZO: r_cfg[apbt_pkg::REG_ROW2_ZO] <= pwdata;
                default: ; // Addresses past the register list are ignored.
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            apbt_pkg::REG_ROW0_XY: prdata = r_cfg[apbt_pkg::REG_ROW0_XY];
            apbt_pkg::REG_ROW0_ZO: prdata = r_cfg[apbt_pkg::REG_ROW0_ZO];
            apbt_pkg::REG_ROW1_XY: prdata = r_cfg[apbt_pkg::REG_ROW1_XY];
            apbt_pkg::REG_ROW1_ZO: prdata = r_cfg[apbt_pkg::REG_ROW1_ZO];
            apbt_pkg::REG_ROW2_XY: prdata = r_cfg[apbt_pkg::REG_ROW2_XY];
            apbt_pkg::REG_ROW2_ZO: prdata = r_cfg[apbt_pkg::REG_ROW2_ZO];
            default:               prdata = '0;
        endcase
    end

    // The pipeline never stalls, so a request is taken whenever start is high.
    assign busy = 1'b0;

    logic w_accept;
    assign w_accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage A: capture the request.
    // ------------------------------------------------------------------
    logic               r_vld_a;
    logic               r_box_a;
    logic               r_off_a;
    logic signed [31:0] r_va [3];
    logic signed [31:0] r_vb [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else begin
            r_vld_a <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // Box mode is decoded from the high command bit alone.
            r_box_a <= i_command[1];
            // Translation is added for points and boxes, not for vectors.
            r_off_a <= (i_command != apbt_pkg::CMD_VECTOR);
            r_va[0] <= i_first_x;
            r_va[1] <= i_first_y;
            r_va[2] <= i_first_z;
            r_vb[0] <= i_second_x;
            r_vb[1] <= i_second_y;
            r_vb[2] <= i_second_z;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: eighteen full-precision products, each entry of the linear
    // part times the matching coordinate of both corners.
    // ------------------------------------------------------------------
    logic               r_vld_b;
    logic               r_box_b;
    logic               r_off_b;
    logic signed [63:0] r_prod_a [3][3];
    logic signed [63:0] r_prod_b [3][3];
    logic signed [31:0] w_m      [3][3];
    logic signed [31:0] w_offs   [3];

    for (genvar r = 0; r < 3; r++) begin : g_mat
        assign w_m[r][0] = r_cfg[2*r][31:0];
        assign w_m[r][1] = r_cfg[2*r][63:32];
        assign w_m[r][2] = r_cfg[2*r+1][31:0];
        assign w_offs[r] = r_cfg[2*r+1][63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else begin
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_box_b <= r_box_a;
        r_off_b <= r_off_a;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_prod_a[r][c] <= w_m[r][c] * r_va[c];
                r_prod_b[r][c] <= w_m[r][c] * r_vb[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage C: round each product toward minus infinity with an arithmetic
    // shift, then sort each term pair. Outside box mode both bounds take
    // the first corner's term.
    // ------------------------------------------------------------------
    logic                                 r_vld_c;
    logic                                 r_off_c;
    logic signed [apbt_pkg::PROD_W-1:0]   r_tlo [3][3];
    logic signed [apbt_pkg::PROD_W-1:0]   r_thi [3][3];
    logic signed [63:0]                   w_sha [3][3];
    logic signed [63:0]                   w_shb [3][3];
    logic signed [apbt_pkg::PROD_W-1:0]   w_pa  [3][3];
    logic signed [apbt_pkg::PROD_W-1:0]   w_pb  [3][3];

    for (genvar r = 0; r < 3; r++) begin : g_rnd_r
        for (genvar c = 0; c < 3; c++) begin : g_rnd_c
            assign w_sha[r][c] = r_prod_a[r][c] >>> apbt_pkg::FRAC_BITS;
            assign w_shb[r][c] = r_prod_b[r][c] >>> apbt_pkg::FRAC_BITS;
            assign w_pa[r][c]  = w_sha[r][c][apbt_pkg::PROD_W-1:0];
            assign w_pb[r][c]  = w_shb[r][c][apbt_pkg::PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
        end else begin
            r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off_c <= r_off_b;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_tlo[r][c] <= (r_box_b && (w_pb[r][c] < w_pa[r][c])) ?
                               w_pb[r][c] : w_pa[r][c];
                r_thi[r][c] <= (r_box_b && (w_pb[r][c] > w_pa[r][c])) ?
                               w_pb[r][c] : w_pa[r][c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage D: sum the three terms of each row and the translation. The
    // sums are wide enough that they cannot wrap.
    // ------------------------------------------------------------------
    logic                                r_vld_d;
    logic signed [apbt_pkg::SUM_W-1:0]   r_slo [3];
    logic signed [apbt_pkg::SUM_W-1:0]   r_shi [3];
    logic signed [apbt_pkg::SUM_W-1:0]   w_sum_lo [3];
    logic signed [apbt_pkg::SUM_W-1:0]   w_sum_hi [3];
    logic signed [apbt_pkg::SUM_W-1:0]   w_offx   [3];

    for (genvar r = 0; r < 3; r++) begin : g_sum
        assign w_offx[r] = r_off_c ?
            {{(apbt_pkg::SUM_W-32){w_offs[r][31]}}, w_offs[r]} : '0;
        assign w_sum_lo[r] =
            {{2{r_tlo[r][0][apbt_pkg::PROD_W-1]}}, r_tlo[r][0]} +
            {{2{r_tlo[r][1][apbt_pkg::PROD_W-1]}}, r_tlo[r][1]} +
            {{2{r_tlo[r][2][apbt_pkg::PROD_W-1]}}, r_tlo[r][2]} + w_offx[r];
        assign w_sum_hi[r] =
            {{2{r_thi[r][0][apbt_pkg::PROD_W-1]}}, r_thi[r][0]} +
            {{2{r_thi[r][1][apbt_pkg::PROD_W-1]}}, r_thi[r][1]} +
            {{2{r_thi[r][2][apbt_pkg::PROD_W-1]}}, r_thi[r][2]} + w_offx[r];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= 1'b0;
        end else begin
            r_vld_d <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_slo[r] <= w_sum_lo[r];
            r_shi[r] <= w_sum_hi[r];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: clamp every bound to the signed 32-bit range and raise the
    // overflow flag if any of the six clamped. This is the output register.
    // ------------------------------------------------------------------
    logic               r_vld_e;
    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];
    logic               r_ovf;
    logic signed [31:0] w_clo [3];
    logic signed [31:0] w_chi [3];
    logic [5:0]         w_sat;

    for (genvar r = 0; r < 3; r++) begin : g_sat
        assign w_sat[r]   = (r_slo[r] > apbt_pkg::SAT_MAX) ||
                            (r_slo[r] < apbt_pkg::SAT_MIN);
        assign w_sat[r+3] = (r_shi[r] > apbt_pkg::SAT_MAX) ||
                            (r_shi[r] < apbt_pkg::SAT_MIN);
        assign w_clo[r] = (r_slo[r] > apbt_pkg::SAT_MAX) ? 32'sh7fff_ffff :
                          (r_slo[r] < apbt_pkg::SAT_MIN) ? 32'sh8000_0000 :
                          r_slo[r][31:0];
        assign w_chi[r] = (r_shi[r] > apbt_pkg::SAT_MAX) ? 32'sh7fff_ffff :
                          (r_shi[r] < apbt_pkg::SAT_MIN) ? 32'sh8000_0000 :
                          r_shi[r][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e <= 1'b0;
        end else begin
            r_vld_e <= r_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_lo[r] <= w_clo[r];
            r_hi[r] <= w_chi[r];
        end
        r_ovf <= |w_sat;
    end

    assign o_done     = r_vld_e;
    assign o_low_x    = r_lo[0];
    assign o_low_y    = r_lo[1];
    assign o_low_z    = r_lo[2];
    assign o_high_x   = r_hi[0];
    assign o_high_y   = r_hi[1];
    assign o_high_z   = r_hi[2];
    assign o_overflow = r_ovf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every accepted request comes out as a result strobe on o_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##5 o_done)
        else $error("request did not produce a result after five cycles");

    // No result appears without a matching earlier request.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(w_accept, 5))
        else $error("result strobe without a matching request");

    // The lower bound never exceeds the upper bound on any axis.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_low_x <= o_high_x) && (o_low_y <= o_high_y) &&
                   (o_low_z <= o_high_z))
        else $error("box lower bound above upper bound");

endmodule
